// ===== rtl/core/wpsd_pkg.sv =====
// Shared constants for the WAV PCM stream decoder: chunk tags, format codes, result kinds, error codes.
package wpsd_pkg;

	localparam int unsigned MAX_CHANNELS = 2;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [15:0] FMT_PCM        = 16'h0001;
	localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FORMAT = 2'd0;
	localparam kind_t KIND_FRAME  = 2'd1;
	localparam kind_t KIND_ERROR  = 2'd2;

	typedef logic [2:0] err_t;
	localparam err_t ERR_NOT_WAVE   = 3'd0;
	localparam err_t ERR_MISSING    = 3'd1;
	localparam err_t ERR_NOT_PCM    = 3'd2;
	localparam err_t ERR_CHANNELS   = 3'd3;
	localparam err_t ERR_DEPTH      = 3'd4;

	localparam int unsigned OUT_TDATA_W = 80;

endpackage

// ===== rtl/core/wav_pcm_stream_decoder.sv =====
// Byte-serial WAV (RIFF/WAVE) parser that emits the format, errors and 16-bit stereo frames.
//
// channel   direction  tdata (low bit up)                                   tuser    tlast
// s_axis    in         data_byte[7:0]                                       -        end_of_stream
// m_axis    out        left_sample, right_sample, rate,                     kind     last_frame
//                      channel_count, bit_depth, error_code, zero pad
//
// One byte per cycle while s_axis is not stalled: each transaction updates the parser state
// and the result register in the same cycle, so the input side runs at one transaction per clock.
// A result appears on m_axis the cycle after its byte; s_axis stalls only while a held
// result is not taken. Bytes that give no result wait on such a held result too.
// arst_n clears the parser to the header phase; end_of_stream does the same, after reporting any
// closing error.
module wav_pcm_stream_decoder
	import wpsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // data_byte
	input  logic                   s_axis_tlast,   // end_of_stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// left_sample[15:0], right_sample[31:16], rate[63:32], channel_count[65:64],
	// bit_depth[71:66], error_code[74:72], zero[79:75]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]             m_axis_tuser,   // kind
	output logic                   m_axis_tlast    // last_frame
);

	localparam logic [2:0] PH_RIFF = 3'd0;
	localparam logic [2:0] PH_CHDR = 3'd1;
	localparam logic [2:0] PH_FMT  = 3'd2;
	localparam logic [2:0] PH_SKIP = 3'd3;
	localparam logic [2:0] PH_PAD  = 3'd4;
	localparam logic [2:0] PH_DATA = 3'd5;
	localparam logic [2:0] PH_DONE = 3'd6;
	localparam logic [2:0] PH_FAIL = 3'd7;

	// parser state
	logic [2:0]  phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [15:0] fcode_q, fcode_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] depth_q, depth_d;
	logic        fmt_ok_q, fmt_ok_d;
	logic [31:0] left_q, left_d;
	logic [3:0]  fidx_q, fidx_d;
	logic [7:0]  fbyte_q [8];

	// result register
	logic        out_vld_q;
	kind_t       out_kind_q;
	logic [15:0] out_left_q, out_right_q;
	logic [31:0] out_rate_q;
	logic [1:0]  out_chan_q;
	logic [5:0]  out_depth_q;
	err_t        out_err_q;
	logic        out_last_q;

	// next result
	logic        res_vld;
	kind_t       res_kind;
	logic [15:0] res_left, res_right;
	logic [31:0] res_rate;
	logic [1:0]  res_chan;
	logic [5:0]  res_depth;
	err_t        res_err;
	logic        res_last;

	logic        acc;
	logic [7:0]  b;
	logic [31:0] pos_inc;
	logic [31:0] tag_nx, len_nx;
	logic [4:0]  fmt_take;
	logic [2:0]  bps;
	logic        mono;
	logic [3:0]  fsize;
	logic        fmt_code_ok, chan_ok, depth_ok;
	logic [31:0] left_dec;
	logic [3:0]  fidx_inc;
	logic        frame_done;
	logic        byte_we;
	logic [7:0]  nb [8];

	assign s_axis_tready = !out_vld_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;

	assign pos_inc  = pos_q + 32'd1;
	assign fmt_take = (len_q < 32'd16) ? len_q[4:0] : 5'd16;
	assign bps      = depth_q[5:3];
	assign mono     = (chan_q == 16'd1);
	assign fsize    = mono ? {1'b0, bps} : {bps, 1'b0};
	assign left_dec = left_q - 32'd1;
	assign fidx_inc = fidx_q + 4'd1;
	assign frame_done = (fidx_inc >= fsize);

	assign fmt_code_ok = (fcode_q == FMT_PCM) || (fcode_q == FMT_EXTENSIBLE);
	assign chan_ok     = (chan_q >= 16'd1) && (chan_q <= 16'(MAX_CHANNELS));
	assign depth_ok    = (depth_q == 16'd8) || (depth_q == 16'd16) ||
	                     (depth_q == 16'd24) || (depth_q == 16'd32);

	// header words with the current byte placed in its lane
	always_comb begin
		tag_nx = (phase_q == PH_CHDR && pos_q == 32'd0) ? 32'd0 : tag_q;
		len_nx = (phase_q == PH_CHDR && pos_q == 32'd0) ? 32'd0 : len_q;
		if (pos_q < 32'd4) begin
			for (int i = 0; i < 4; i++) begin
				if (pos_q[1:0] == 2'(i)) tag_nx[i*8 +: 8] = b;
			end
		end else if ((phase_q == PH_CHDR) || (pos_q >= 32'd8)) begin
			for (int i = 0; i < 4; i++) begin
				if (pos_q[1:0] == 2'(i)) len_nx[i*8 +: 8] = b;
			end
		end
	end

	// frame bytes with the current byte merged
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			nb[i] = (fidx_q[2:0] == 3'(i)) ? b : fbyte_q[i];
		end
	end

	always_comb begin
		case (bps)
			3'd1: begin
				res_left  = {nb[0] ^ 8'h80, 8'h00};
				res_right = {nb[1] ^ 8'h80, 8'h00};
			end
			3'd2: begin
				res_left  = {nb[1], nb[0]};
				res_right = {nb[3], nb[2]};
			end
			3'd3: begin
				res_left  = {nb[2], nb[1]};
				res_right = {nb[5], nb[4]};
			end
			default: begin
				res_left  = {nb[3], nb[2]};
				res_right = {nb[7], nb[6]};
			end
		endcase
		if (mono) res_right = res_left;
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		tag_d    = tag_q;
		len_d    = len_q;
		fcode_d  = fcode_q;
		chan_d   = chan_q;
		rate_d   = rate_q;
		depth_d  = depth_q;
		fmt_ok_d = fmt_ok_q;
		left_d   = left_q;
		fidx_d   = fidx_q;
		byte_we  = 1'b0;
		res_vld  = 1'b0;
		res_kind = KIND_FORMAT;
		res_rate = 32'd0;
		res_chan = 2'd0;
		res_depth = 6'd0;
		res_err  = ERR_NOT_WAVE;
		res_last = 1'b0;

		if (s_axis_tlast) begin
			// report what is missing, then return to the header phase
			if (phase_q == PH_RIFF) begin
				res_vld  = 1'b1;
				res_kind = KIND_ERROR;
				res_err  = ERR_NOT_WAVE;
			end else if (phase_q <= PH_PAD) begin
				res_vld  = 1'b1;
				res_kind = KIND_ERROR;
				res_err  = ERR_MISSING;
			end
			phase_d  = PH_RIFF;
			pos_d    = 32'd0;
			tag_d    = 32'd0;
			len_d    = 32'd0;
			fmt_ok_d = 1'b0;
		end else begin
			unique case (phase_q)
				PH_RIFF: begin
					tag_d = tag_nx;
					len_d = len_nx;
					pos_d = pos_inc;
					if (pos_inc == 32'd12) begin
						pos_d = 32'd0;
						if (tag_nx != TAG_RIFF || len_nx != TAG_WAVE) begin
							phase_d  = PH_FAIL;
							res_vld  = 1'b1;
							res_kind = KIND_ERROR;
							res_err  = ERR_NOT_WAVE;
						end else begin
							phase_d = PH_CHDR;
						end
					end
				end
				PH_CHDR: begin
					tag_d = tag_nx;
					len_d = len_nx;
					pos_d = pos_inc;
					if (pos_inc == 32'd8) begin
						pos_d = 32'd0;
						if (tag_nx == TAG_FMT) begin
							fcode_d = 16'd0;
							chan_d  = 16'd0;
							rate_d  = 32'd0;
							depth_d = 16'd0;
							if (len_nx == 32'd0) begin
								fmt_ok_d = 1'b1;
								phase_d  = PH_CHDR;
							end else begin
								phase_d = PH_FMT;
							end
						end else if (tag_nx == TAG_DATA) begin
							res_vld  = 1'b1;
							res_kind = KIND_ERROR;
							phase_d  = PH_FAIL;
							if (!fmt_ok_q) begin
								res_err = ERR_MISSING;
							end else if (!fmt_code_ok) begin
								res_err = ERR_NOT_PCM;
							end else if (!chan_ok) begin
								res_err = ERR_CHANNELS;
							end else if (!depth_ok) begin
								res_err = ERR_DEPTH;
							end else begin
								res_kind  = KIND_FORMAT;
								res_rate  = rate_q;
								res_chan  = chan_q[1:0];
								res_depth = depth_q[5:0];
								left_d    = len_nx;
								fidx_d    = 4'd0;
								phase_d   = (len_nx < {28'd0, fsize}) ? PH_DONE : PH_DATA;
							end
						end else begin
							phase_d = (len_nx == 32'd0) ? PH_CHDR : PH_SKIP;
						end
					end
				end
				PH_FMT: begin
					case (pos_q[3:0])
						4'd0:  fcode_d[7:0]    = b;
						4'd1:  fcode_d[15:8]   = b;
						4'd2:  chan_d[7:0]     = b;
						4'd3:  chan_d[15:8]    = b;
						4'd4:  rate_d[7:0]     = b;
						4'd5:  rate_d[15:8]    = b;
						4'd6:  rate_d[23:16]   = b;
						4'd7:  rate_d[31:24]   = b;
						4'd14: depth_d[7:0]    = b;
						4'd15: depth_d[15:8]   = b;
						default: ;
					endcase
					pos_d = pos_inc;
					if (pos_inc >= {27'd0, fmt_take}) begin
						fmt_ok_d = 1'b1;
						if (len_q > pos_inc) begin
							phase_d = PH_SKIP;
						end else begin
							phase_d = len_q[0] ? PH_PAD : PH_CHDR;
							pos_d   = 32'd0;
						end
					end
				end
				PH_SKIP: begin
					pos_d = pos_inc;
					if (pos_inc >= len_q) begin
						phase_d = len_q[0] ? PH_PAD : PH_CHDR;
						pos_d   = 32'd0;
					end
				end
				PH_PAD: begin
					phase_d = PH_CHDR;
					pos_d   = 32'd0;
				end
				PH_DATA: begin
					byte_we = 1'b1;
					left_d  = left_dec;
					fidx_d  = fidx_inc;
					if (frame_done) begin
						res_vld  = 1'b1;
						res_kind = KIND_FRAME;
						res_last = (left_dec < {28'd0, fsize});
						fidx_d   = 4'd0;
						if (res_last) phase_d = PH_DONE;
					end
				end
				PH_DONE, PH_FAIL: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RIFF;
			pos_q    <= 32'd0;
			tag_q    <= 32'd0;
			len_q    <= 32'd0;
			fmt_ok_q <= 1'b0;
		end else if (acc) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			tag_q    <= tag_d;
			len_q    <= len_d;
			fmt_ok_q <= fmt_ok_d;
		end
	end

	// payload state: written before it is read, no reset needed
	always_ff @(posedge clk) begin
		if (acc) begin
			fcode_q <= fcode_d;
			chan_q  <= chan_d;
			rate_q  <= rate_d;
			depth_q <= depth_d;
			left_q  <= left_d;
			fidx_q  <= fidx_d;
			if (byte_we) fbyte_q[fidx_q[2:0]] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_vld_q <= acc && res_vld;
		end
	end

	// hold the result until the downstream transaction completes
	always_ff @(posedge clk) begin
		if (acc && res_vld) begin
			out_kind_q  <= res_kind;
			out_left_q  <= (res_kind == KIND_FRAME) ? res_left : 16'd0;
			out_right_q <= (res_kind == KIND_FRAME) ? res_right : 16'd0;
			out_rate_q  <= res_rate;
			out_chan_q  <= res_chan;
			out_depth_q <= res_depth;
			out_err_q   <= (res_kind == KIND_ERROR) ? res_err : ERR_NOT_WAVE;
			out_last_q  <= res_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_err_q, out_depth_q, out_chan_q, out_rate_q,
	                        out_right_q, out_left_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== verif/tb_wav_pcm_stream_decoder.sv =====
// Self-checking testbench for the WAV PCM stream decoder: scripted and random WAV files.
`timescale 1ns / 1ps

module tb_wav_pcm_stream_decoder
	import wpsd_pkg::*;
();

	typedef enum logic [3:0] {
		PH_RIFF, PH_CHDR, PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_DONE, PH_FAIL
	} parse_phase_t;

	typedef enum logic {CHK_MODEL, CHK_ERROR} row_check_t;

	// Same bit order as {m_axis_tuser, m_axis_tlast, m_axis_tdata}
	typedef struct packed {
		kind_t       kind;
		logic        last;
		logic [4:0]  pad;
		err_t        err;
		logic [5:0]  depth;
		logic [1:0]  chans;
		logic [31:0] rate;
		logic [15:0] right;
		logic [15:0] left;
	} wav_result_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
		row_check_t chk;
		err_t       err;
	} script_row_t;

	// Error rows carry a typed result in place of the model's; every row goes through the parser model
	localparam script_row_t SCRIPT [0:27] = '{
		'{8'hFF, 1'b1, CHK_ERROR, ERR_NOT_WAVE},
		'{8'h52, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h49, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h46, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h58, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h00, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h00, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h00, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h00, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h57, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h41, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h56, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h45, 1'b0, CHK_ERROR, ERR_NOT_WAVE},
		'{8'h00, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h00, 1'b1, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h52, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h49, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h46, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h46, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'hFF, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'hFF, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'hFF, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'hFF, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h57, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h41, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h56, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h45, 1'b0, CHK_MODEL, ERR_NOT_WAVE},
		'{8'h00, 1'b1, CHK_ERROR, ERR_MISSING}
	};

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'h00;   // data_byte
	logic                   s_axis_tlast = 1'b0;    // end_of_stream
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// left_sample, right_sample, rate, channel_count, bit_depth, error_code, zero pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;           // kind
	logic                   m_axis_tlast;           // last_frame

	wav_pcm_stream_decoder DUT (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
	);

	// Parser model state
	parse_phase_t ps_phase;
	logic [31:0]  ps_pos, ps_tag, ps_len, ps_rate, ps_left;
	logic [15:0]  ps_fcode, ps_chans, ps_depth;
	logic         ps_fmt_seen;
	logic [63:0]  ps_frame;
	logic [3:0]   ps_fidx;

	wav_result_t pending_results[$];
	wav_result_t seen_res, due_res;
	logic [7:0]  file_q[$];

	bit          tx_calm = 1'b0, rx_calm = 1'b0;
	int unsigned rx_hold = 0;
	int unsigned n_bad = 0, n_live = 0, n_files = 0;
	int unsigned n_format = 0, n_frame = 0, n_error = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("timeout with %0d results pending", pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void clear_parser();
		ps_phase    = PH_RIFF;
		ps_pos      = '0;
		ps_tag      = '0;
		ps_len      = '0;
		ps_fcode    = '0;
		ps_chans    = '0;
		ps_rate     = '0;
		ps_depth    = '0;
		ps_fmt_seen = 1'b0;
		ps_left     = '0;
		ps_frame    = '0;
		ps_fidx     = '0;
	endfunction

	function automatic void end_chunk_body();
		ps_phase = ps_len[0] ? PH_PAD : PH_CHDR;
		ps_pos   = '0;
	endfunction

	function automatic int unsigned frame_bytes();
		return int'(ps_depth / 16'd8) * int'(ps_chans);
	endfunction

	function automatic wav_result_t error_result(input err_t code);
		wav_result_t res;
		res      = '0;
		res.kind = KIND_ERROR;
		res.err  = code;
		return res;
	endfunction

	// Keep the top 16 bits of a sample; 8-bit samples are unsigned
	function automatic logic [15:0] sample_at(input int unsigned at);
		int unsigned bps;
		bps = ps_depth / 8;
		if (bps == 1)
			return {ps_frame[8*at +: 8] ^ 8'h80, 8'h00};
		return ps_frame[8*(at+bps-2) +: 16];
	endfunction

	function automatic void parse_wav_byte(input logic [7:0] b, input logic eos,
			output bit hit, output wav_result_t res);
		logic [31:0] pos;
		int unsigned fs, bps, take;
		hit = 1'b0;
		res = '0;
		pos = ps_pos;
		if (eos) begin
			if (ps_phase == PH_RIFF) begin
				hit = 1'b1;
				res = error_result(ERR_NOT_WAVE);
			end else if (ps_phase inside {PH_CHDR, PH_FMT, PH_SKIP, PH_PAD}) begin
				hit = 1'b1;
				res = error_result(ERR_MISSING);
			end
			clear_parser();
			return;
		end
		ps_pos = pos + 1;
		case (ps_phase)
			PH_RIFF: begin
				if (pos < 4)
					ps_tag[8*pos +: 8] = b;
				else if (pos >= 8)
					ps_len[8*(pos-8) +: 8] = b;
				if (ps_pos == 12) begin
					if (ps_tag != TAG_RIFF || ps_len != TAG_WAVE) begin
						ps_phase = PH_FAIL;
						hit = 1'b1;
						res = error_result(ERR_NOT_WAVE);
					end else begin
						ps_phase = PH_CHDR;
						ps_pos = '0;
					end
				end
			end
			PH_CHDR: begin
				if (pos == 0) begin
					ps_tag = '0;
					ps_len = '0;
				end
				if (pos < 4)
					ps_tag[8*pos +: 8] = b;
				else
					ps_len[8*(pos-4) +: 8] = b;
				if (ps_pos == 8) begin
					ps_pos = '0;
					if (ps_tag == TAG_FMT) begin
						ps_fcode = '0;
						ps_chans = '0;
						ps_rate  = '0;
						ps_depth = '0;
						if (ps_len == 0) begin
							ps_fmt_seen = 1'b1;
							end_chunk_body();
						end else
							ps_phase = PH_FMT;
					end else if (ps_tag == TAG_DATA) begin
						hit = 1'b1;
						if (!ps_fmt_seen)
							res = error_result(ERR_MISSING);
						else if (ps_fcode != FMT_PCM && ps_fcode != FMT_EXTENSIBLE)
							res = error_result(ERR_NOT_PCM);
						else if (ps_chans < 1 || ps_chans > MAX_CHANNELS)
							res = error_result(ERR_CHANNELS);
						else if (!(ps_depth inside {16'd8, 16'd16, 16'd24, 16'd32}))
							res = error_result(ERR_DEPTH);
						else begin
							res.kind  = KIND_FORMAT;
							res.rate  = ps_rate;
							res.chans = ps_chans[1:0];
							res.depth = ps_depth[5:0];
							ps_left   = ps_len;
							ps_frame  = '0;
							ps_fidx   = '0;
							ps_phase  = (ps_left < frame_bytes()) ? PH_DONE : PH_DATA;
						end
						if (res.kind == KIND_ERROR)
							ps_phase = PH_FAIL;
					end else
						ps_phase = (ps_len == 0) ? PH_CHDR : PH_SKIP;
				end
			end
			PH_FMT: begin
				take = (ps_len < 16) ? ps_len : 16;
				if (pos < 2)
					ps_fcode[8*pos +: 8] = b;
				else if (pos < 4)
					ps_chans[8*(pos-2) +: 8] = b;
				else if (pos < 8)
					ps_rate[8*(pos-4) +: 8] = b;
				else if (pos >= 14 && pos < 16)
					ps_depth[8*(pos-14) +: 8] = b;
				if (ps_pos >= take) begin
					ps_fmt_seen = 1'b1;
					if (ps_len > ps_pos)
						ps_phase = PH_SKIP;
					else
						end_chunk_body();
				end
			end
			PH_SKIP: begin
				if (ps_pos >= ps_len)
					end_chunk_body();
			end
			PH_PAD: begin
				ps_phase = PH_CHDR;
				ps_pos = '0;
			end
			PH_DATA: begin
				fs  = frame_bytes();
				bps = ps_depth / 8;
				ps_frame[8*ps_fidx +: 8] = b;
				ps_fidx++;
				ps_left--;
				if (ps_fidx >= fs) begin
					hit = 1'b1;
					res.kind  = KIND_FRAME;
					res.left  = sample_at(0);
					res.right = (ps_chans == 1) ? res.left : sample_at(bps);
					res.last  = ps_left < fs;
					if (res.last)
						ps_phase = PH_DONE;
					ps_frame = '0;
					ps_fidx  = '0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_q.push_back(w[8*i +: 8]);
	endfunction

	function automatic void put_other_chunk();
		logic [31:0] tag;
		int unsigned len;
		tag = $urandom;
		if (tag == TAG_FMT || tag == TAG_DATA)
			tag = TAG_RIFF;
		len = $urandom_range(0, 6);
		put_word(tag);
		put_word(len);
		repeat (len + len % 2)
			file_q.push_back(8'($urandom));
	endfunction

	// Mostly well-formed files; a share with broken headers, missing or cut chunks
	function automatic void build_file();
		int unsigned shape, n_fmt, r, nsend;
		int unsigned flen = 0;
		logic [31:0]  dlen, w;
		logic [15:0]  fcode, chans, depth;
		logic [127:0] img;
		file_q.delete();
		shape = $urandom_range(99);
		put_word(TAG_RIFF);
		put_word($urandom);
		put_word(TAG_WAVE);
		if (shape < 5) begin
			// flip one bit of a tag byte, never of the size field
			r = $urandom_range(7);
			if (r >= 4)
				r += 4;
			file_q[r] = file_q[r] ^ (8'h01 << $urandom_range(7));
			repeat ($urandom_range(0, 4))
				file_q.push_back(8'($urandom));
			return;
		end
		if (shape < 8) begin
			repeat ($urandom_range(1, 12))
				void'(file_q.pop_back());
			return;
		end
		repeat ($urandom_range(0, 2))
			put_other_chunk();
		n_fmt = (shape < 12) ? 0 : ($urandom_range(9) == 0) ? 2 : 1;
		repeat (n_fmt) begin
			r = $urandom_range(99);
			fcode = (r < 45) ? FMT_PCM : (r < 88) ? FMT_EXTENSIBLE : 16'($urandom);
			r = $urandom_range(99);
			chans = (r < 88) ? 16'($urandom_range(1, 2)) : (r < 93) ? 16'd0 :
				(r < 96) ? 16'd3 : 16'($urandom);
			r = $urandom_range(99);
			depth = (r < 85) ? 16'(8 * $urandom_range(1, 4)) :
				(r < 93) ? 16'($urandom_range(0, 40)) : 16'($urandom);
			img = {depth, 48'({$urandom, $urandom}), 32'($urandom), chans, fcode};
			r = $urandom_range(99);
			flen = (r < 65) ? 16 : (r < 75) ? 18 : (r < 85) ? 40 : $urandom_range(0, 15);
			put_word(TAG_FMT);
			put_word(flen);
			for (int i = 0; i < flen; i++)
				file_q.push_back((i < 16) ? img[8*i +: 8] : 8'($urandom));
			if (flen[0])
				file_q.push_back(8'($urandom));
		end
		if (shape >= 12 && shape < 16) begin
			// end the stream inside the last fmt chunk
			repeat ($urandom_range(1, flen + 1))
				void'(file_q.pop_back());
			return;
		end
		repeat ($urandom_range(0, 1))
			put_other_chunk();
		if (shape >= 16 && shape < 20)
			return;
		put_word(TAG_DATA);
		r = $urandom_range(99);
		if (r < 5)
			dlen = 32'hFFFF_FFFF;
		else if (r < 15)
			dlen = $urandom_range(1, 7);
		else if (r < 20)
			dlen = $urandom_range(64, 160);
		else
			dlen = $urandom_range(0, 40);
		put_word(dlen);
		r = $urandom_range(99);
		if (dlen > 160)
			nsend = $urandom_range(0, 48);
		else if (r < 20)
			nsend = $urandom_range(0, dlen);
		else if (r < 35)
			nsend = dlen + $urandom_range(1, 6);
		else
			nsend = dlen;
		repeat (nsend) begin
			w = $urandom;
			// a quarter of the samples sit on 00, 7F, 80 or FF
			file_q.push_back((w[9:8] == 2'b00) ? ({8{w[10]}} ^ {w[11], 7'h00}) : w[7:0]);
		end
	endfunction

	// Call at a falling edge; returns at the falling edge after the transaction
	task automatic push_byte(input logic [7:0] b, input logic eos,
			input row_check_t chk, input err_t code);
		int unsigned idle;
		bit          hit;
		wav_result_t res;
		idle = pick_gap(tx_calm);
		if (idle != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eos;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (eos || !(ps_phase inside {PH_DONE, PH_FAIL}))
			n_live++;
		parse_wav_byte(b, eos, hit, res);
		if (chk == CHK_ERROR)
			pending_results.push_back(error_result(code));
		else if (hit)
			pending_results.push_back(res);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(2) == 0)
				rx_hold <= pick_gap(rx_calm);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_res = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
			case (seen_res.kind)
				KIND_FORMAT: n_format++;
				KIND_FRAME:  n_frame++;
				default:     n_error++;
			endcase
			if (pending_results.size() == 0) begin
				if (n_bad < 10)
					$display("%0t: result with nothing pending: kind %0d tdata %h",
						$time, seen_res.kind, m_axis_tdata);
				n_bad++;
			end else begin
				due_res = pending_results.pop_front();
				if (seen_res !== due_res) begin
					if (n_bad < 10) begin
						$display("%0t: mismatch (exp/got) kind %0d/%0d left %0d/%0d right %0d/%0d last %0d/%0d",
							$time, due_res.kind, seen_res.kind,
							$signed(due_res.left), $signed(seen_res.left),
							$signed(due_res.right), $signed(seen_res.right),
							due_res.last, seen_res.last);
						$display("    rate %0d/%0d chans %0d/%0d depth %0d/%0d err %0d/%0d pad %0d/%0d",
							due_res.rate, seen_res.rate, due_res.chans, seen_res.chans,
							due_res.depth, seen_res.depth, due_res.err, seen_res.err,
							due_res.pad, seen_res.pad);
					end
					n_bad++;
				end
			end
		end
	end

	initial begin
		clear_parser();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < $size(SCRIPT); i++)
			push_byte(SCRIPT[i].data, SCRIPT[i].eos, SCRIPT[i].chk, SCRIPT[i].err);
		while (n_live < 1400) begin
			tx_calm = ($urandom_range(4) == 0);
			rx_calm = ($urandom_range(4) == 0);
			build_file();
			n_files++;
			foreach (file_q[i])
				push_byte(file_q[i], 1'b0, CHK_MODEL, ERR_NOT_WAVE);
			push_byte(8'($urandom), 1'b1, CHK_MODEL, ERR_NOT_WAVE);
		end
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d scripted transactions and %0d random files, %0d live bytes",
			$size(SCRIPT), n_files, n_live);
		$display("results seen: %0d format, %0d frame, %0d error; %0d mismatches",
			n_format, n_frame, n_error, n_bad);
		if (n_bad == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
